### hdl/kuz_pkg.sv
`timescale 1ns / 1ps
package kuz_pkg;

   localparam int unsigned NumRoundKeys = 10;
   localparam int unsigned NumCells     = 9;
   localparam int unsigned NumSteps     = 32;
   localparam logic [7:0]  PolyLow      = 8'hC3;

   typedef logic [127:0]                     block_type;
   typedef logic [127:0][127:0]              lmat_type;
   typedef logic [NumSteps-1:0][127:0]       cons_type;
   typedef logic [NumRoundKeys-1:0][127:0]   rkeys_type;

   // one item travelling down the cell chain
   typedef struct packed {
      logic      dec;
      block_type data;
   } stage_type;

   localparam logic [7:0] SBOX [256] = '{
      8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
      8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
      8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
      8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
      8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
      8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
      8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
      8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
      8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
      8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
      8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
      8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
      8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
      8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
      8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
      8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
      8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
      8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
      8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
      8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
      8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
      8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
      8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
      8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
      8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
      8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
      8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
      8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
      8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
      8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
      8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
      8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
   };

   localparam logic [7:0] SBOX_INV [256] = '{
      8'd165,8'd45,8'd50,8'd143,8'd14,8'd48,8'd56,8'd192,
      8'd84,8'd230,8'd158,8'd57,8'd85,8'd126,8'd82,8'd145,
      8'd100,8'd3,8'd87,8'd90,8'd28,8'd96,8'd7,8'd24,
      8'd33,8'd114,8'd168,8'd209,8'd41,8'd198,8'd164,8'd63,
      8'd224,8'd39,8'd141,8'd12,8'd130,8'd234,8'd174,8'd180,
      8'd154,8'd99,8'd73,8'd229,8'd66,8'd228,8'd21,8'd183,
      8'd200,8'd6,8'd112,8'd157,8'd65,8'd117,8'd25,8'd201,
      8'd170,8'd252,8'd77,8'd191,8'd42,8'd115,8'd132,8'd213,
      8'd195,8'd175,8'd43,8'd134,8'd167,8'd177,8'd178,8'd91,
      8'd70,8'd211,8'd159,8'd253,8'd212,8'd15,8'd156,8'd47,
      8'd155,8'd67,8'd239,8'd217,8'd121,8'd182,8'd83,8'd127,
      8'd193,8'd240,8'd35,8'd231,8'd37,8'd94,8'd181,8'd30,
      8'd162,8'd223,8'd166,8'd254,8'd172,8'd34,8'd249,8'd226,
      8'd74,8'd188,8'd53,8'd202,8'd238,8'd120,8'd5,8'd107,
      8'd81,8'd225,8'd89,8'd163,8'd242,8'd113,8'd86,8'd17,
      8'd106,8'd137,8'd148,8'd101,8'd140,8'd187,8'd119,8'd60,
      8'd123,8'd40,8'd171,8'd210,8'd49,8'd222,8'd196,8'd95,
      8'd204,8'd207,8'd118,8'd44,8'd184,8'd216,8'd46,8'd54,
      8'd219,8'd105,8'd179,8'd20,8'd149,8'd190,8'd98,8'd161,
      8'd59,8'd22,8'd102,8'd233,8'd92,8'd108,8'd109,8'd173,
      8'd55,8'd97,8'd75,8'd185,8'd227,8'd186,8'd241,8'd160,
      8'd133,8'd131,8'd218,8'd71,8'd197,8'd176,8'd51,8'd250,
      8'd150,8'd111,8'd110,8'd194,8'd246,8'd80,8'd255,8'd93,
      8'd169,8'd142,8'd23,8'd27,8'd151,8'd125,8'd236,8'd88,
      8'd247,8'd31,8'd251,8'd124,8'd9,8'd13,8'd122,8'd103,
      8'd69,8'd135,8'd220,8'd232,8'd79,8'd29,8'd78,8'd4,
      8'd235,8'd248,8'd243,8'd62,8'd61,8'd189,8'd138,8'd136,
      8'd221,8'd205,8'd11,8'd19,8'd152,8'd2,8'd147,8'd128,
      8'd144,8'd208,8'd36,8'd52,8'd203,8'd237,8'd244,8'd206,
      8'd153,8'd16,8'd68,8'd64,8'd146,8'd58,8'd1,8'd38,
      8'd18,8'd26,8'd72,8'd104,8'd245,8'd129,8'd139,8'd199,
      8'd214,8'd32,8'd10,8'd8,8'd0,8'd76,8'd215,8'd116
   };

   localparam logic [7:0] LCOEF [16] = '{
      8'h94, 8'h20, 8'h85, 8'h10, 8'hc2, 8'hc0, 8'h01, 8'hfb,
      8'h01, 8'hc0, 8'hc2, 8'h10, 8'h85, 8'h20, 8'h94, 8'h01
   };

   // GF(2^8) product, used only when building the constant matrices and iteration constants
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      acc = '0;
      x   = a;
      y   = b;
      for (int n = 0; n < 8; n++) begin
         if (y[0]) acc = acc ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? PolyLow : 8'h00);
         y = {1'b0, y[7:1]};
      end
      return acc;
   endfunction

   // reference form of L and its inverse, byte 0 in the top bits
   function automatic block_type lin_slow(input block_type v, input logic inv);
      logic [7:0] a [16];
      logic [7:0] acc;
      logic [7:0] first;
      for (int n = 0; n < 16; n++) a[n] = v[127-8*n -: 8];
      for (int r = 0; r < 16; r++) begin
         if (!inv) begin
            acc = '0;
            for (int n = 0; n < 16; n++) acc = acc ^ gmul(a[n], LCOEF[n]);
            for (int n = 15; n > 0; n--) a[n] = a[n-1];
            a[0] = acc;
         end else begin
            first = a[0];
            for (int n = 0; n < 15; n++) a[n] = a[n+1];
            a[15] = first;
            acc = '0;
            for (int n = 0; n < 16; n++) acc = acc ^ gmul(a[n], LCOEF[n]);
            a[15] = acc;
         end
      end
      for (int n = 0; n < 16; n++) lin_slow[127-8*n -: 8] = a[n];
   endfunction

   // L is linear over GF(2): row i is the image of input bit i
   function automatic lmat_type build_lmat(input logic inv);
      lmat_type m;
      for (int i = 0; i < 128; i++) m[i] = lin_slow(block_type'(1) << i, inv);
      return m;
   endfunction

   function automatic cons_type build_cons();
      cons_type c;
      for (int i = 0; i < NumSteps; i++)
         c[i] = lin_slow(block_type'(i + 1), 1'b0);
      return c;
   endfunction

   localparam lmat_type LMAT     = build_lmat(1'b0);
   localparam lmat_type LMAT_INV = build_lmat(1'b1);
   localparam cons_type ITER_C   = build_cons();

   function automatic block_type lin_apply(input lmat_type m, input block_type x);
      block_type r;
      r = '0;
      for (int i = 0; i < 128; i++) if (x[i]) r = r ^ m[i];
      return r;
   endfunction

   function automatic block_type sub16(input block_type x, input logic inv);
      block_type r;
      for (int n = 0; n < 16; n++)
         r[8*n +: 8] = inv ? SBOX_INV[x[8*n +: 8]] : SBOX[x[8*n +: 8]];
      return r;
   endfunction

endpackage

### hdl/kuz_round_cell.sv
`timescale 1ns / 1ps
// One round of the chain: enc = L(S(x ^ ke)), dec = Sinv(Linv(x)) ^ kd
module kuz_round_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  kuz_pkg::stage_type    in_item,
   input  kuz_pkg::block_type    key_enc,
   input  kuz_pkg::block_type    key_dec,
   output logic                  out_valid,
   input  logic                  out_ready,
   output kuz_pkg::stage_type    out_item
);

   logic               valid_ff, valid_in;
   kuz_pkg::stage_type item_ff, item_in;
   kuz_pkg::block_type enc_y, dec_y;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      enc_y = kuz_pkg::lin_apply(kuz_pkg::LMAT,
                 kuz_pkg::sub16(in_item.data ^ key_enc, 1'b0));
      dec_y = kuz_pkg::sub16(kuz_pkg::lin_apply(kuz_pkg::LMAT_INV, in_item.data), 1'b1)
              ^ key_dec;
      item_in.dec  = in_item.dec;
      item_in.data = in_item.dec ? dec_y : enc_y;
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### hdl/kuz_key_sched.sv
`timescale 1ns / 1ps
// Key registers and round key expansion, one Feistel step per cycle
module kuz_key_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [63:0]           csr_data,
   output kuz_pkg::rkeys_type    round_keys,
   output logic                  busy
);

   logic [3:0][63:0]    key_ff, key_in;
   kuz_pkg::block_type  a1_ff, a1_in, a0_ff, a0_in, step_t;
   kuz_pkg::rkeys_type  rk_ff, rk_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [3:0]          rk_idx;

   always_comb begin
      key_in  = key_ff;
      a1_in   = a1_ff;
      a0_in   = a0_ff;
      rk_in   = rk_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rk_idx  = {cnt_ff[5:3], 1'b0};
      step_t  = kuz_pkg::lin_apply(kuz_pkg::LMAT,
                   kuz_pkg::sub16(a1_ff ^ kuz_pkg::ITER_C[cnt_ff[4:0] - 5'd1], 1'b0))
                ^ a0_ff;
      if (csr_valid) begin
         // new key word: restart the schedule
         key_in[csr_index] = csr_data;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            a1_in    = {key_ff[0], key_ff[1]};
            a0_in    = {key_ff[2], key_ff[3]};
            rk_in[0] = {key_ff[0], key_ff[1]};
            rk_in[1] = {key_ff[2], key_ff[3]};
            cnt_in   = 6'd1;
         end else begin
            a1_in = step_t;
            a0_in = a1_ff;
            if (cnt_ff[2:0] == 3'd0) begin
               rk_in[rk_idx]        = step_t;
               rk_in[rk_idx + 4'd1] = a1_ff;
            end
            if (cnt_ff == 6'(kuz_pkg::NumSteps)) begin
               busy_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         key_ff  <= key_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      a1_ff <= a1_in;
      a0_ff <= a0_in;
      rk_ff <= rk_in;
   end

   assign round_keys = rk_ff;
   assign busy       = busy_ff;

endmodule

### hdl/kuznyechik_block_cipher.sv
`timescale 1ns / 1ps
// Kuznyechik 128-bit block cipher, 256-bit key. Each request carries one
// block and a flag (req_tuser: 0 encrypt, 1 decrypt); one response block
// comes back per request, in order. The data path is a chain of nine round
// cells plus an output register, so a new request is taken every cycle while
// the response side is not stalled and the key schedule is idle. Each cell
// has its own handshake, so bubbles close up under back-pressure. Key words
// are written over the csr port (index 0..3, word 0 holds key bytes 0..7,
// byte 0 most significant). After reset and after any key write the round
// keys are re-expanded by one shared Feistel step unit, during which
// req_tready stays low; it is also low in a cycle where a key write is
// offered. Write keys only while no block is in flight.
module kuznyechik_block_cipher (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // [63:0] block_hi, [127:64] block_lo
   input  logic          req_tuser,   // [0] action: 0 encrypt, 1 decrypt
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // [63:0] result_hi, [127:64] result_lo
   // key register writes
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_data
);

   kuz_pkg::rkeys_type  rk;
   logic                busy;

   logic               valid_c [kuz_pkg::NumCells+1];
   logic               ready_c [kuz_pkg::NumCells+1];
   kuz_pkg::stage_type item_c  [kuz_pkg::NumCells+1];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [127:0]       rsp_data_ff, rsp_data_in;
   kuz_pkg::block_type blk;
   logic               out_take;

   assign csr_ready = 1'b1;

   kuz_key_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .round_keys (rk),
      .busy       (busy)
   );

   // decrypt starts with the last round key; byte 0 is the top byte
   assign blk          = {req_tdata[63:0], req_tdata[127:64]};
   assign item_c[0].dec  = req_tuser;
   assign item_c[0].data = blk ^ (req_tuser ? rk[kuz_pkg::NumRoundKeys-1] : '0);
   assign valid_c[0]   = req_tvalid && !busy && !csr_valid;
   assign req_tready   = ready_c[0] && !busy && !csr_valid;

   for (genvar j = 0; j < kuz_pkg::NumCells; j++) begin : g_cell
      kuz_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_c[j]),
         .in_ready  (ready_c[j]),
         .in_item   (item_c[j]),
         .key_enc   (rk[j]),
         .key_dec   (rk[kuz_pkg::NumCells-1-j]),
         .out_valid (valid_c[j+1]),
         .out_ready (ready_c[j+1]),
         .out_item  (item_c[j+1])
      );
   end

   // output register: encrypt ends with the last round key
   assign ready_c[kuz_pkg::NumCells] = !rsp_valid_ff || rsp_tready;
   assign out_take = ready_c[kuz_pkg::NumCells];

   always_comb begin
      rsp_valid_in = out_take ? valid_c[kuz_pkg::NumCells] : rsp_valid_ff;
      rsp_data_in  = item_c[kuz_pkg::NumCells].data
                     ^ (item_c[kuz_pkg::NumCells].dec ? '0 : rk[kuz_pkg::NumRoundKeys-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[63:0], rsp_data_ff[127:64]};

endmodule

### tb/sv/kuznyechik_block_cipher_checker.sv
`timescale 1ns / 1ps
module kuznyechik_block_cipher_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data,
   output int           fail_count,
   output int           pending
);

   typedef logic [7:0] bytes_type [16];

   logic [63:0]  key_words [4];
   logic [127:0] rkeys [10];
   logic [127:0] blocks_due [$];

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int n = 0; n < 8; n++) begin
         if (b[0]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'hC3 : 8'h00);
         b = b >> 1;
      end
      return acc;
   endfunction

   function automatic logic [7:0] lin_row(bytes_type a);
      logic [7:0] acc;
      acc = '0;
      for (int n = 0; n < 16; n++) acc ^= gf_mul(a[n], kuz_pkg::LCOEF[n]);
      return acc;
   endfunction

   // byte 0 is the top byte
   function automatic logic [127:0] mix(logic [127:0] v, logic inv);
      bytes_type a;
      logic [7:0] t;
      logic [127:0] r;
      for (int n = 0; n < 16; n++) a[n] = v[127-8*n -: 8];
      for (int k = 0; k < 16; k++) begin
         if (!inv) begin
            t = lin_row(a);
            for (int n = 15; n > 0; n--) a[n] = a[n-1];
            a[0] = t;
         end else begin
            t = a[0];
            for (int n = 0; n < 15; n++) a[n] = a[n+1];
            a[15] = t;
            a[15] = lin_row(a);
         end
      end
      for (int n = 0; n < 16; n++) r[127-8*n -: 8] = a[n];
      return r;
   endfunction

   function automatic logic [127:0] subst(logic [127:0] v, logic inv);
      for (int n = 0; n < 16; n++)
         v[8*n +: 8] = inv ? kuz_pkg::SBOX_INV[v[8*n +: 8]] : kuz_pkg::SBOX[v[8*n +: 8]];
      return v;
   endfunction

   task automatic schedule_keys();
      logic [127:0] a1, a0, t;
      a1 = {key_words[0], key_words[1]};
      a0 = {key_words[2], key_words[3]};
      rkeys[0] = a1;
      rkeys[1] = a0;
      for (int i = 1; i <= 32; i++) begin
         t = mix(subst(a1 ^ mix(128'(i), 1'b0), 1'b0), 1'b0) ^ a0;
         a0 = a1;
         a1 = t;
         if (i % 8 == 0) begin
            rkeys[i/4] = a1;
            rkeys[i/4 + 1] = a0;
         end
      end
   endtask

   function automatic logic [127:0] cipher(logic [127:0] d, logic dec);
      if (!dec) begin
         for (int i = 0; i < 9; i++) d = mix(subst(d ^ rkeys[i], 1'b0), 1'b0);
         d ^= rkeys[9];
      end else begin
         d ^= rkeys[9];
         for (int i = 8; i >= 0; i--) d = subst(mix(d, 1'b1), 1'b1) ^ rkeys[i];
      end
      return d;
   endfunction

   always @(posedge clock) begin
      logic [127:0] want, got, in_blk;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_words[i] = '0;
         schedule_keys();
         blocks_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            key_words[csr_index] = csr_data;
            schedule_keys();
         end
         if (req_tvalid && req_tready) begin
            // tdata: block_hi low, block_lo high
            in_blk = {req_tdata[63:0], req_tdata[127:64]};
            want = cipher(in_blk, req_tuser);
            blocks_due.push_back({want[63:0], want[127:64]});
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (blocks_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = blocks_due.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("mismatch: hi exp %h got %h, lo exp %h got %h",
                        want[63:0], got[63:0], want[127:64], got[127:64]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= blocks_due.size();
   end
endmodule

### tb/sv/kuznyechik_block_cipher_test.sv
`timescale 1ns / 1ps
module kuznyechik_block_cipher_test;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;
   int           fail_count;
   int           pending;
   int           idle_cycles = 0;
   bit           calm = 0;      // no idling on either side
   bit           hold_rsp = 0;  // long response stall

   localparam int WatchdogLimit = 20000;

   kuznyechik_block_cipher u_top (.*);

   kuznyechik_block_cipher_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // response side: random stalls, a long hold when asked
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 0;
      else rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
   end

   // watchdog: cycles with nothing accepted
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_key(logic [1:0] idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one request; random gap ahead of it unless calm
   task automatic send_block(logic dec, logic [63:0] hi, logic [63:0] lo);
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= dec;
      req_tdata  <= {lo, hi};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick64();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero key first, field extremes both ways
      for (int d = 0; d < 2; d++) begin
         send_block(d[0], '0, '0);
         send_block(d[0], '1, '1);
         send_block(d[0], 64'h8000_0000_0000_0000, 64'h1);
         send_block(d[0], 64'h1122334455667700, 64'hffeeddccbbaa9988);
      end
      end_burst();
      drain();

      // standard test key, plus its known plaintext/ciphertext
      write_key(0, 64'h8899aabbccddeeff);
      write_key(1, 64'h0011223344556677);
      write_key(2, 64'hfedcba9876543210);
      write_key(3, 64'h0123456789abcdef);
      send_block(0, 64'h1122334455667700, 64'hffeeddccbbaa9988);
      send_block(1, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd);
      send_block(0, '1, '0);
      send_block(1, '0, '1);
      end_burst();
      drain();

      // all-ones key
      for (int i = 0; i < 4; i++) write_key(i[1:0], '1);
      send_block(0, '0, '0);
      send_block(1, '1, '1);
      end_burst();
      drain();

      // random phases, each under a fresh key
      for (int ph = 0; ph < 8; ph++) begin
         for (int i = 0; i < 4; i++) write_key(i[1:0], pick64());
         calm = (ph == 2);
         if (ph == 4) fork
            begin
               hold_rsp = 1;
               repeat (300) @(posedge clock);
               hold_rsp = 0;
            end
         join_none
         for (int n = 0; n < 250; n++) begin
            send_block(1'($urandom_range(1)), pick64(), pick64());
            // sender pauses until everything is back
            if (ph == 5 && n == 120) begin
               end_burst();
               while (pending != 0) @(posedge clock);
            end
         end
         end_burst();
         drain();
      end
      calm = 0;

      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

### filelist.f
hdl/kuz_pkg.sv
hdl/kuz_round_cell.sv
hdl/kuz_key_sched.sv
hdl/kuznyechik_block_cipher.sv
tb/sv/kuznyechik_block_cipher_checker.sv
tb/sv/kuznyechik_block_cipher_test.sv
